>>> design/urmt_pkg.sv
// ----------------------------------------------------------------------------
// urmt_pkg
// Shared types and codes for the usable region merge table.
// ----------------------------------------------------------------------------
package urmt_pkg;

    // operation codes of an input transfer
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // result action codes
    typedef enum logic [2:0] {
        ACT_COVERED = 3'd0,
        ACT_BOTH    = 3'd1,
        ACT_START   = 3'd2,
        ACT_END     = 3'd3,
        ACT_APPEND  = 3'd4,
        ACT_FULL    = 3'd5,
        ACT_READ    = 3'd6
    } t_action;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN1,
        ST_ALIGN2,
        ST_SCAN,
        ST_MERGE,
        ST_TAIL,
        ST_RDOUT
    } t_state;

endpackage

>>> design/urmt_align.sv
// ----------------------------------------------------------------------------
// urmt_align
// Two-stage page alignment of a region: base rounded down, base plus size
// rounded up, both with 64-bit wrap. A load fills the first stage; results leave the second.
// ----------------------------------------------------------------------------
module urmt_align (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [63:0] i_base,
    input  logic [63:0] i_size,
    input  logic [4:0]  i_page_shift,
    output logic [63:0] o_lo,
    output logic [63:0] o_hi
);
    logic [63:0] r_base;
    logic [63:0] r_sum;
    logic [63:0] r_lo;
    logic [63:0] r_hi;
    logic [63:0] page_m1;

    // page size minus one, from the shift
    assign page_m1 = (64'd1 << i_page_shift) - 64'd1;

    // first stage: capture base and raw end
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_base <= i_base;
            r_sum  <= i_base + i_size;
        end
    end

    // second stage: round both bounds to the page
    always_ff @(posedge i_clk) begin
        r_lo <= r_base & ~page_m1;
        r_hi <= (r_sum + page_m1) & ~page_m1;
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;
endmodule

>>> design/usable_region_merge_table.sv
// ----------------------------------------------------------------------------
// usable_region_merge_table
// Table of page-aligned memory regions. An add merges the region into the first
// overlapping entry, else appends it or drops it if full; a read returns one entry.
//
//   channel   direction  handshake                  payload
//   command   in         start / busy               i_operation, i_region_base,
//                                                   i_region_size, i_read_index
//   result    out        o_result_valid (strobe)    o_action, o_entry_index,
//                                                   o_entry_start, o_entry_end,
//                                                   o_entry_count
//   config    in         i_cfg_we                   i_cfg_wdata (page shift)
//
// A read fetches the entry into the memory read register, then the result
// registers. An add aligns the region, scans one entry per cycle (up to
// MAX_REGIONS) over the region memory's single read port, then merges or appends.
// Synchronous active-low reset empties the table and sets the page shift to
// 12; the memory itself is not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module usable_region_merge_table #(
    parameter int MAX_REGIONS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_operation,
    input  logic [63:0]              i_region_base,
    input  logic [63:0]              i_region_size,
    input  logic [4:0]               i_read_index,
    input  logic                     i_cfg_we,
    input  logic [4:0]               i_cfg_wdata,
    output logic                     o_result_valid,
    output urmt_pkg::t_action        o_action,
    output logic [4:0]               o_entry_index,
    output logic [63:0]              o_entry_start,
    output logic [63:0]              o_entry_end,
    output logic [5:0]               o_entry_count
);
    import urmt_pkg::*;

    localparam int IW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW   = $clog2(MAX_REGIONS + 1);
    localparam int CMPW = ((CW > 5) ? CW : 5) + 1;

    // control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_cidx, n_cidx;
    logic [4:0]      r_page_shift;
    logic [4:0]      r_rd_index;

    // entry under merge
    logic [63:0]     r_us, r_ue;

    // result registers
    logic            r_res_valid, n_res_valid;
    t_action         r_act, n_act;
    logic [4:0]      r_idx, n_idx;
    logic [63:0]     r_start, n_start;
    logic [63:0]     r_end, n_end;
    logic [5:0]      r_cnt_out, n_cnt_out;

    // region memory: start in the upper half, end in the lower half
    logic [127:0]    r_mem [MAX_REGIONS];
    logic [127:0]    r_rdata;
    logic [IW-1:0]   mem_raddr;
    logic [IW-1:0]   mem_waddr;
    logic [127:0]    mem_wdata;
    logic            mem_we;

    logic [63:0]     lo, hi;
    logic [63:0]     rd_us, rd_ue;
    logic            accept;
    logic            rd_ok;
    logic            scan_last;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);
    assign rd_us  = r_rdata[127:64];
    assign rd_ue  = r_rdata[63:0];

    // page alignment unit
    urmt_align u_align (
        .i_clk        (i_clk),
        .i_load       (accept),
        .i_base       (i_region_base),
        .i_size       (i_region_size),
        .i_page_shift (r_page_shift),
        .o_lo         (lo),
        .o_hi         (hi)
    );

    // read request in range of both the count and the table
    assign rd_ok = (CMPW'(r_rd_index) < CMPW'(r_count)) &&
                   (CMPW'(r_rd_index) < CMPW'(MAX_REGIONS));

    // entry under compare is the last valid one
    assign scan_last = ((CW'(r_cidx) + CW'(1)) == r_count);

    // memory read address
    always_comb begin
        case (r_state)
            ST_IDLE:   mem_raddr = IW'(i_read_index);
            ST_ALIGN2: mem_raddr = '0;
            ST_SCAN:   mem_raddr = r_cidx + IW'(1);
            default:   mem_raddr = r_cidx;
        endcase
    end

    // memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_shift <= 5'd12;
        end else if (i_cfg_we) begin
            r_page_shift <= i_cfg_wdata;
        end
    end

    // command capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_index <= i_read_index;
        end
    end

    // entry held for merge
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN) begin
            r_us <= rd_us;
            r_ue <= rd_ue;
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_cidx      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cidx      <= n_cidx;
            r_res_valid <= n_res_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_idx     <= n_idx;
        r_start   <= n_start;
        r_end     <= n_end;
        r_cnt_out <= n_cnt_out;
    end

    // sequencer: next state, memory write and result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cidx      = r_cidx;
        n_res_valid = 1'b0;
        n_act       = r_act;
        n_idx       = r_idx;
        n_start     = r_start;
        n_end       = r_end;
        n_cnt_out   = r_cnt_out;
        mem_we      = 1'b0;
        mem_waddr   = r_cidx;
        mem_wdata   = {lo, hi};
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_operation == OP_READ) ? ST_RDOUT : ST_ALIGN1;
                end
            end
            ST_ALIGN1: begin
                n_state = ST_ALIGN2;
            end
            ST_ALIGN2: begin
                n_cidx  = '0;
                n_state = (r_count == '0) ? ST_TAIL : ST_SCAN;
            end
            ST_SCAN: begin
                if ((lo < rd_ue) && (hi > rd_us)) begin
                    n_state = ST_MERGE;
                end else if (scan_last) begin
                    n_state = ST_TAIL;
                end else begin
                    n_cidx = r_cidx + IW'(1);
                end
            end
            ST_MERGE: begin
                // widen the first overlapping entry as needed
                n_state     = ST_IDLE;
                n_res_valid = 1'b1;
                n_idx       = 5'(r_cidx);
                n_cnt_out   = 6'(r_count);
                n_start     = (lo < r_us) ? lo : r_us;
                n_end       = (hi > r_ue) ? hi : r_ue;
                if (lo >= r_us && hi <= r_ue) begin
                    n_act = ACT_COVERED;
                end else if (lo < r_us && hi > r_ue) begin
                    n_act = ACT_BOTH;
                end else if (lo < r_us) begin
                    n_act = ACT_START;
                end else begin
                    n_act = ACT_END;
                end
                mem_we    = (n_act != ACT_COVERED);
                mem_wdata = {n_start, n_end};
            end
            ST_TAIL: begin
                // no overlap: append, or drop when the table is full
                n_state     = ST_IDLE;
                n_res_valid = 1'b1;
                n_start     = lo;
                n_end       = hi;
                if (CMPW'(r_count) >= CMPW'(MAX_REGIONS)) begin
                    n_act     = ACT_FULL;
                    n_idx     = '0;
                    n_cnt_out = 6'(r_count);
                end else begin
                    n_act     = ACT_APPEND;
                    n_idx     = 5'(r_count);
                    n_count   = r_count + CW'(1);
                    n_cnt_out = 6'(n_count);
                    mem_we    = 1'b1;
                    mem_waddr = IW'(r_count);
                end
            end
            ST_RDOUT: begin
                n_state     = ST_IDLE;
                n_res_valid = 1'b1;
                n_act       = ACT_READ;
                n_idx       = r_rd_index;
                n_cnt_out   = 6'(r_count);
                n_start     = rd_ok ? rd_us : 64'd0;
                n_end       = rd_ok ? rd_ue : 64'd0;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_result_valid = r_res_valid;
    assign o_action       = r_act;
    assign o_entry_index  = r_idx;
    assign o_entry_start  = r_start;
    assign o_entry_end    = r_end;
    assign o_entry_count  = r_cnt_out;
endmodule

>>> design/urmt_checker.sv
// ----------------------------------------------------------------------------
// urmt_checker
// Port-level checks of the usable region merge table, bound to the top level.
// ----------------------------------------------------------------------------
module urmt_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              o_result_valid,
    input  urmt_pkg::t_action o_action,
    input  logic [4:0]        o_entry_index,
    input  logic [5:0]        o_entry_count
);
    import urmt_pkg::*;

    // an accepted command always makes the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after command transfer");

    // a result is only shown once the block has gone idle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    // results never come back to back
    a_result_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("two results in consecutive cycles");

    // an append lands on the entry at the old count, one below the new count
    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_action == ACT_APPEND) |->
            (o_entry_count[4:0] == o_entry_index + 5'd1))
        else $error("append index and count disagree");

    // a dropped region reports entry zero
    a_full_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_action == ACT_FULL) |-> (o_entry_index == 5'd0))
        else $error("full drop with non-zero index");
endmodule

bind usable_region_merge_table urmt_checker u_urmt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_action       (o_action),
    .o_entry_index  (o_entry_index),
    .o_entry_count  (o_entry_count)
);
